// ===== sv/qslerp_pkg.sv =====
// Shared types, fixed-point widths, constants and the rounding helper of the
// approximate quaternion interpolator. Depends on nothing.
`default_nettype none

package qslerp_pkg;

	localparam int PW = 16;
	localparam int DW = 17;
	localparam int QW = 18;
	localparam int RW = 19;
	localparam int SW = 25;
	localparam int KW = 26;
	localparam int IW = 21;
	localparam int NUM_STAGES = 20;

	typedef struct packed {
		logic [PW-1:0]        blend_t;
		logic signed [PW-1:0] start_w;
		logic signed [PW-1:0] start_x;
		logic signed [PW-1:0] start_y;
		logic signed [PW-1:0] start_z;
		logic signed [PW-1:0] end_w;
		logic signed [PW-1:0] end_x;
		logic signed [PW-1:0] end_y;
		logic signed [PW-1:0] end_z;
	} slerp_in_t;

	typedef struct packed {
		logic signed [PW-1:0] out_w;
		logic signed [PW-1:0] out_x;
		logic signed [PW-1:0] out_y;
		logic signed [PW-1:0] out_z;
	} slerp_out_t;

	localparam logic signed [QW-1:0] Q_ONE   = 18'sd32768;
	localparam logic signed [QW-1:0] Q_HALF  = 18'sd16384;
	localparam logic signed [QW-1:0] Q_THREE = 18'sd98304;
	localparam logic signed [QW-1:0] C_N     = 18'sd31427;
	localparam logic signed [QW-1:0] C_A     = 18'sd33470;
	localparam logic signed [QW-1:0] C_F     = 18'sd17449;
	localparam logic signed [QW-1:0] C_TH1   = 18'sd29990;
	localparam logic signed [QW-1:0] C_TH2   = 18'sd21369;
	localparam logic signed [QW-1:0] C_S     = 18'sd26964;
	localparam logic signed [QW-1:0] C_KC    = 18'sd19186;

	// Right shift that rounds half up, toward positive infinity on ties.
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
		input int unsigned sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

endpackage

`default_nettype wire

// ===== sv/qslerp_stream_if.sv =====
// Valid/ready stream interface used for both channels of the interpolator.
// The payload type is chosen by the instantiating level.
`default_nettype none

interface qslerp_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== sv/quaternion_slerp_approx_top.sv =====
// Approximate quaternion interpolation between two unit quaternions with a
// cubic correction of the blend fraction and an iterated linear renormalization.
// Depends on qslerp_pkg and qslerp_stream_if.
//
// Usage:
// The sink channel slerp_in takes one transaction per pair of quaternions and
// a blend fraction; the source channel slerp_out returns one transaction with
// the normalized, saturated result for each input, in order.
// The datapath is a 20-stage pipeline, so a new transaction is accepted every
// cycle as long as the receiver takes results. The longest chain is the pair
// of inverse-square-root refinement steps, four stages each, which sets the depth.
// Reset clears all stage valid bits; no results are presented until new
// transactions arrive. When the receiver holds ready low while a result is
// waiting, the whole pipeline freezes and slerp_in.ready drops in the same
// cycle; nothing is lost or repeated, and streaming resumes at full rate.
`default_nettype none

module quaternion_slerp_approx_top
	import qslerp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	qslerp_stream_if.sink   slerp_in,
	qslerp_stream_if.source slerp_out
);

	typedef struct {
		logic signed [QW-1:0] u;
		logic                 mir;
		logic signed [PW-1:0] p [4];
		logic signed [DW-1:0] d [4];
		logic signed [QW-1:0] poly;
	} fctx_t;

	typedef struct {
		logic signed [RW-1:0] r [4];
		logic signed [SW-1:0] s;
		logic                 th1;
		logic                 th2;
		logic signed [KW-1:0] k0;
		logic signed [IW-1:0] k1;
	} nctx_t;

	logic                  adv;
	logic [NUM_STAGES:1]   vld_q;

	fctx_t                 fctx_c;
	fctx_t                 fctx2_c;
	fctx_t                 fctx_s [1:7];
	logic signed [31:0]    pq_c [4];
	logic signed [31:0]    pq_s1 [4];
	logic signed [QW-1:0]  c_c, c_s2, poly_c;
	logic signed [QW-1:0]  fac_c, fac_s3;
	logic signed [QW-1:0]  ff_c, ff_s4;
	logic signed [QW-1:0]  kk_c, kk_s5;
	logic signed [QW-1:0]  inner_c, inner_s6;
	logic signed [QW-1:0]  tp_c, tp_s7;
	logic signed [RW-1:0]  r_c [4];
	logic signed [RW-1:0]  r_s8 [4];
	logic signed [RW-1:0]  r_s9 [4];
	logic signed [2*RW-1:0] sq_c [4];
	logic signed [2*RW-1:0] sq_s9 [4];
	nctx_t                 nctx_c;
	nctx_t                 nctx11_c;
	nctx_t                 nctx15_c;
	nctx_t                 nctx_s [10:19];
	logic signed [KW-1:0]  k0_c;
	logic signed [IW-1:0]  kka_c, kka_s12, xa_c, xa_s13, ia_c, ia_s14, k1_c;
	logic signed [IW-1:0]  kkb_c, kkb_s16, xb_c, xb_s17, ib_c, ib_s18, k2_c, k2_s19;
	slerp_out_t            out_c, out_s20;

	assign adv             = !vld_q[NUM_STAGES] || slerp_out.ready;
	assign slerp_in.ready  = adv;
	assign slerp_out.valid = vld_q[NUM_STAGES];
	assign slerp_out.data  = out_s20;

	always_comb begin
		logic [16:0]          t_cl;
		logic [16:0]          u_v;
		logic signed [PW-1:0] pin [4];
		logic signed [PW-1:0] qin [4];
		pin[0] = slerp_in.data.start_w;
		pin[1] = slerp_in.data.start_x;
		pin[2] = slerp_in.data.start_y;
		pin[3] = slerp_in.data.start_z;
		qin[0] = slerp_in.data.end_w;
		qin[1] = slerp_in.data.end_x;
		qin[2] = slerp_in.data.end_y;
		qin[3] = slerp_in.data.end_z;
		t_cl = (slerp_in.data.blend_t > 16'd32768) ? 17'd32768 : {1'b0, slerp_in.data.blend_t};
		fctx_c.mir = t_cl > 17'(Q_HALF);
		u_v = fctx_c.mir ? (17'd32768 - t_cl) : t_cl;
		fctx_c.u = signed'(QW'(u_v));
		fctx_c.poly = '0;
		for (int i = 0; i < 4; i++) begin
			fctx_c.p[i] = pin[i];
			fctx_c.d[i] = DW'(qin[i]) - DW'(pin[i]);
			pq_c[i] = pin[i] * qin[i];
		end
	end

	always_comb begin
		logic signed [33:0]     dot;
		logic signed [21:0]     dr;
		logic signed [QW-1:0]   w2;
		logic signed [2*QW-1:0] mp;
		dot = '0;
		for (int i = 0; i < 4; i++) begin
			dot = dot + 34'(pq_s1[i]);
		end
		dr = 22'(rnd(64'(dot), 13));
		if (dr > 22'sd32768) begin
			c_c = Q_ONE;
		end else if (dr < -22'sd32768) begin
			c_c = -Q_ONE;
		end else begin
			c_c = QW'(dr);
		end
		w2 = (fctx_s[1].u <<< 1) - Q_THREE;
		mp = fctx_s[1].u * w2;
		poly_c = QW'(rnd(64'(mp), 15));
		fctx2_c = fctx_s[1];
		fctx2_c.poly = poly_c;
	end

	always_comb begin
		logic signed [2*QW-1:0] m3, m4, m5, m6, m7;
		logic signed [QW-1:0]   b;
		m3 = C_S * c_s2;
		fac_c = Q_ONE - QW'(rnd(64'(m3), 15));
		m4 = fac_s3 * fac_s3;
		ff_c = QW'(rnd(64'(m4), 15));
		m5 = C_KC * ff_s4;
		kk_c = QW'(rnd(64'(m5), 15));
		m6 = kk_s5 * fctx_s[5].poly;
		inner_c = QW'(rnd(64'(m6), 15)) + Q_ONE + kk_s5;
		m7 = fctx_s[6].u * inner_s6;
		b = QW'(rnd(64'(m7), 15));
		tp_c = fctx_s[6].mir ? (Q_ONE - b) : b;
	end

	always_comb begin
		logic signed [QW+DW-1:0] m8;
		logic signed [2*RW+1:0]  sum;
		sum = '0;
		for (int i = 0; i < 4; i++) begin
			m8 = tp_s7 * fctx_s[7].d[i];
			r_c[i] = RW'(fctx_s[7].p[i]) + RW'(rnd(64'(m8), 15));
			sq_c[i] = r_s8[i] * r_s8[i];
			sum = sum + (2*RW+2)'(sq_s9[i]);
			nctx_c.r[i] = r_s9[i];
		end
		nctx_c.s = SW'(rnd(64'(sum), 13));
		nctx_c.th1 = nctx_c.s <= SW'(C_TH1);
		nctx_c.th2 = nctx_c.s <= SW'(C_TH2);
		nctx_c.k0 = '0;
		nctx_c.k1 = '0;
	end

	always_comb begin
		logic signed [SW+QW-1:0] m11;
		logic signed [2*IW-1:0]  m12, m13, m15, m16, m17, m19;
		logic signed [IW+QW-1:0] m14, m18;
		m11 = SW'(C_F) * (nctx_s[10].s - SW'(C_N));
		k0_c = KW'(C_A) - KW'(rnd(64'(m11), 15));
		nctx11_c = nctx_s[10];
		nctx11_c.k0 = k0_c;
		m12 = IW'(nctx_s[11].k0) * IW'(nctx_s[11].k0);
		kka_c = IW'(rnd(64'(m12), 15));
		m13 = kka_s12 * IW'(nctx_s[12].s);
		xa_c = IW'(rnd(64'(m13), 15));
		m14 = IW'(C_F) * (xa_s13 - IW'(C_N));
		ia_c = IW'(C_A) - IW'(rnd(64'(m14), 15));
		m15 = IW'(nctx_s[14].k0) * ia_s14;
		k1_c = IW'(rnd(64'(m15), 15));
		nctx15_c = nctx_s[14];
		nctx15_c.k1 = k1_c;
		m16 = nctx_s[15].k1 * nctx_s[15].k1;
		kkb_c = IW'(rnd(64'(m16), 15));
		m17 = kkb_s16 * IW'(nctx_s[16].s);
		xb_c = IW'(rnd(64'(m17), 15));
		m18 = IW'(C_F) * (xb_s17 - IW'(C_N));
		ib_c = IW'(C_A) - IW'(rnd(64'(m18), 15));
		m19 = nctx_s[18].k1 * ib_s18;
		k2_c = IW'(rnd(64'(m19), 15));
	end

	always_comb begin
		logic signed [KW-1:0]    kf;
		logic signed [RW+KW-1:0] mo;
		logic signed [RW+KW-15:0] vr;
		logic signed [PW-1:0]    sat [4];
		if (nctx_s[19].th2) begin
			kf = KW'(k2_s19);
		end else if (nctx_s[19].th1) begin
			kf = KW'(nctx_s[19].k1);
		end else begin
			kf = nctx_s[19].k0;
		end
		for (int i = 0; i < 4; i++) begin
			mo = nctx_s[19].r[i] * kf;
			vr = (RW+KW-14)'(rnd(64'(mo), 15));
			if (vr > (RW+KW-14)'(32767)) begin
				sat[i] = 16'sh7fff;
			end else if (vr < -(RW+KW-14)'(32768)) begin
				sat[i] = -16'sh8000;
			end else begin
				sat[i] = PW'(vr);
			end
		end
		out_c.out_w = sat[0];
		out_c.out_x = sat[1];
		out_c.out_y = sat[2];
		out_c.out_z = sat[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NUM_STAGES-1:1], slerp_in.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fctx_s[1] <= fctx_c;
			pq_s1     <= pq_c;
			fctx_s[2] <= fctx2_c;
			for (int n = 3; n <= 7; n++) begin
				fctx_s[n] <= fctx_s[n-1];
			end
			c_s2     <= c_c;
			fac_s3   <= fac_c;
			ff_s4    <= ff_c;
			kk_s5    <= kk_c;
			inner_s6 <= inner_c;
			tp_s7    <= tp_c;
			r_s8     <= r_c;
			r_s9     <= r_s8;
			sq_s9    <= sq_c;
			nctx_s[10] <= nctx_c;
			nctx_s[11] <= nctx11_c;
			for (int n = 12; n <= 14; n++) begin
				nctx_s[n] <= nctx_s[n-1];
			end
			nctx_s[15] <= nctx15_c;
			for (int n = 16; n <= 19; n++) begin
				nctx_s[n] <= nctx_s[n-1];
			end
			kka_s12 <= kka_c;
			xa_s13  <= xa_c;
			ia_s14  <= ia_c;
			kkb_s16 <= kkb_c;
			xb_s17  <= xb_c;
			ib_s18  <= ib_c;
			k2_s19  <= k2_c;
			out_s20 <= out_c;
		end
	end

endmodule

`default_nettype wire

// ===== bench/quaternion_slerp_approx_top_test.sv =====
// Self-checking bench for quaternion_slerp_approx_top: a directed table, then random quaternion
// pairs, with every result compared against a table value or a bit-exact fixed-point predictor.
// Depends on qslerp_pkg, qslerp_stream_if and the block under test.

module quaternion_slerp_approx_top_test;
	import qslerp_pkg::*;

	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     RANDOM_ITEMS   = 1500;
	localparam int     DRAIN_CYCLES   = 40;
	localparam longint UNITY    = Q_ONE;
	localparam longint HALF_FR  = Q_HALF;
	localparam longint NORM_PT  = C_N;
	localparam longint ISQ_BASE = C_A;
	localparam longint ISQ_GAIN = C_F;
	localparam longint STEP_TH1 = C_TH1;
	localparam longint STEP_TH2 = C_TH2;
	localparam longint DOT_GAIN = C_S;
	localparam longint CUBIC_K  = C_KC;

	typedef struct {
		slerp_in_t  item;
		bit         known;
		slerp_out_t result;
	} table_row_t;

	logic clk;
	logic arst_n;

	qslerp_stream_if #(.T(slerp_in_t))  in_if ();
	qslerp_stream_if #(.T(slerp_out_t)) out_if ();

	quaternion_slerp_approx_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.slerp_in  (in_if),
		.slerp_out (out_if)
	);

	table_row_t directed_rows[$];
	slerp_out_t pending_results[$];
	int         mismatch_count = 0;
	int         idle_cycles = 0;

	function automatic longint round_shr(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint inv_sqrt_line(longint x);
		return ISQ_BASE - round_shr(ISQ_GAIN * (x - NORM_PT), 15);
	endfunction

	function automatic longint warp_fraction(longint u, longint c);
		longint factor, gain, poly, inner;
		factor = UNITY - round_shr(DOT_GAIN * c, 15);
		gain = round_shr(CUBIC_K * round_shr(factor * factor, 15), 15);
		poly = round_shr(u * (2 * u - 3 * UNITY), 15);
		inner = round_shr(gain * poly, 15) + UNITY + gain;
		return round_shr(u * inner, 15);
	endfunction

	function automatic slerp_out_t predict_slerp(slerp_in_t it);
		longint p[4], q[4], r[4], o[4];
		longint t, c, tp, dot, sq, s, k;
		slerp_out_t res;
		p[0] = longint'(it.start_w);
		p[1] = longint'(it.start_x);
		p[2] = longint'(it.start_y);
		p[3] = longint'(it.start_z);
		q[0] = longint'(it.end_w);
		q[1] = longint'(it.end_x);
		q[2] = longint'(it.end_y);
		q[3] = longint'(it.end_z);
		t = longint'(it.blend_t);
		if (t > UNITY)
			t = UNITY;
		dot = 0;
		for (int i = 0; i < 4; i++)
			dot += p[i] * q[i];
		c = clip(round_shr(dot, 13), -UNITY, UNITY);
		if (t <= HALF_FR)
			tp = warp_fraction(t, c);
		else
			tp = UNITY - warp_fraction(UNITY - t, c);
		sq = 0;
		for (int i = 0; i < 4; i++) begin
			r[i] = p[i] + round_shr(tp * (q[i] - p[i]), 15);
			sq += r[i] * r[i];
		end
		s = round_shr(sq, 13);
		k = inv_sqrt_line(s);
		if (s <= STEP_TH1) begin
			k = round_shr(k * inv_sqrt_line(round_shr(round_shr(k * k, 15) * s, 15)), 15);
			if (s <= STEP_TH2)
				k = round_shr(k * inv_sqrt_line(round_shr(round_shr(k * k, 15) * s, 15)), 15);
		end
		for (int i = 0; i < 4; i++)
			o[i] = clip(round_shr(r[i] * k, 15), -32768, 32767);
		res.out_w = 16'(o[0]);
		res.out_x = 16'(o[1]);
		res.out_y = 16'(o[2]);
		res.out_z = 16'(o[3]);
		return res;
	endfunction

	function automatic void add_row(int t, int pw, int px, int py, int pz, int qw, int qx,
		int qy, int qz, bit known, int ow, int ox, int oy, int oz);
		table_row_t row;
		row.item = '{16'(t), 16'(pw), 16'(px), 16'(py), 16'(pz), 16'(qw), 16'(qx),
			16'(qy), 16'(qz)};
		row.known = known;
		row.result = '{16'(ow), 16'(ox), 16'(oy), 16'(oz)};
		directed_rows.push_back(row);
	endfunction

	function automatic void unit_quat(input real scale, output logic signed [15:0] w,
		output logic signed [15:0] x, output logic signed [15:0] y,
		output logic signed [15:0] z);
		real a[4];
		real n;
		do begin
			for (int i = 0; i < 4; i++)
				a[i] = real'($urandom_range(0, 65536)) - 32768.0;
			n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
		end while (n < 1.0);
		w = 16'($rtoi(a[0] * scale / n));
		x = 16'($rtoi(a[1] * scale / n));
		y = 16'($rtoi(a[2] * scale / n));
		z = 16'($rtoi(a[3] * scale / n));
	endfunction

	function automatic slerp_in_t random_item();
		slerp_in_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.blend_t = 16'($urandom_range(0, 32768));
		if (pick < 70) begin
			unit_quat(16384.0, it.start_w, it.start_x, it.start_y, it.start_z);
			unit_quat(16384.0, it.end_w, it.end_x, it.end_y, it.end_z);
			if (pick >= 60)
				it.blend_t = 16'($urandom_range(0, 65535));
		end else if (pick < 82) begin
			unit_quat(real'($urandom_range(500, 32767)), it.start_w, it.start_x, it.start_y,
				it.start_z);
			unit_quat(real'($urandom_range(500, 32767)), it.end_w, it.end_x, it.end_y,
				it.end_z);
		end else if (pick < 92) begin
			it.blend_t = 16'($urandom_range(0, 65535));
			it.start_w = 16'($urandom_range(0, 65535));
			it.start_x = 16'($urandom_range(0, 65535));
			it.start_y = 16'($urandom_range(0, 65535));
			it.start_z = 16'($urandom_range(0, 65535));
			it.end_w = 16'($urandom_range(0, 65535));
			it.end_x = 16'($urandom_range(0, 65535));
			it.end_y = 16'($urandom_range(0, 65535));
			it.end_z = 16'($urandom_range(0, 65535));
		end else begin
			unit_quat(16384.0, it.start_w, it.start_x, it.start_y, it.start_z);
			case ($urandom_range(0, 2))
				0: begin
					it.end_w = it.start_w;
					it.end_x = it.start_x;
					it.end_y = it.start_y;
					it.end_z = it.start_z;
				end
				1: begin
					it.end_w = -it.start_w;
					it.end_x = -it.start_x;
					it.end_y = -it.start_y;
					it.end_z = -it.start_z;
				end
				default: begin
					it.end_w = 16'(it.start_w + $signed($urandom_range(0, 64)) - 32);
					it.end_x = 16'(it.start_x + $signed($urandom_range(0, 64)) - 32);
					it.end_y = 16'(it.start_y + $signed($urandom_range(0, 64)) - 32);
					it.end_z = 16'(it.start_z + $signed($urandom_range(0, 64)) - 32);
				end
			endcase
		end
		return it;
	endfunction

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	task automatic send_item(input slerp_in_t it, input slerp_out_t expected, input int gap);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= it;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		pending_results.push_back(expected);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		bit level;
		int hold;
		level = 1'b0;
		hold = 0;
		out_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				level = !level;
				hold = level ? $urandom_range(1, 60) : 1 + idle_len();
			end
			out_if.ready <= level;
			hold--;
		end
	end

	always @(posedge clk) begin
		slerp_out_t got, want;
		if (out_if.valid && out_if.ready) begin
			got = out_if.data;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result w=%0d x=%0d y=%0d z=%0d", got.out_w,
						got.out_x, got.out_y, got.out_z);
			end else begin
				want = pending_results.pop_front();
				if (got.out_w !== want.out_w || got.out_x !== want.out_x ||
					got.out_y !== want.out_y || got.out_z !== want.out_z) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
							want.out_w, want.out_x, want.out_y, want.out_z,
							got.out_w, got.out_x, got.out_y, got.out_z);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		slerp_in_t  it;
		slerp_out_t expected;
		int         gap;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.data = '0;

		add_row(0,     0, 0, 0, 0,    0, 0, 0, 0,    1, 0, 0, 0, 0);
		add_row(32768, 0, 0, 0, 0,    0, 0, 0, 0,    1, 0, 0, 0, 0);
		add_row(65535, 0, 0, 0, 0,    0, 0, 0, 0,    1, 0, 0, 0, 0);
		add_row(0,     16384, 0, 0, 0,    16384, 0, 0, 0,    0, 0, 0, 0, 0);
		add_row(32768, 16384, 0, 0, 0,    0, 16384, 0, 0,    0, 0, 0, 0, 0);
		add_row(32769, 16384, 0, 0, 0,    0, 16384, 0, 0,    0, 0, 0, 0, 0);
		add_row(65535, 16384, 0, 0, 0,    0, 16384, 0, 0,    0, 0, 0, 0, 0);
		add_row(16384, 16384, 0, 0, 0,    0, 16384, 0, 0,    0, 0, 0, 0, 0);
		add_row(16385, 16384, 0, 0, 0,    0, 16384, 0, 0,    0, 0, 0, 0, 0);
		add_row(1,     16384, 0, 0, 0,    0, 16384, 0, 0,    0, 0, 0, 0, 0);
		add_row(32767, 16384, 0, 0, 0,    0, 16384, 0, 0,    0, 0, 0, 0, 0);
		add_row(8192,  32767, 32767, 32767, 32767,    32767, 32767, 32767, 32767,
			0, 0, 0, 0, 0);
		add_row(20000, -32768, -32768, -32768, -32768,    32767, 32767, 32767, 32767,
			0, 0, 0, 0, 0);
		add_row(65535, -32768, -32768, -32768, -32768,    -32768, -32768, -32768, -32768,
			0, 0, 0, 0, 0);
		add_row(16384, 16384, 0, 0, 0,    -16384, 0, 0, 0,    0, 0, 0, 0, 0);
		add_row(12000, 0, 0, 0, 4000,    0, 0, 0, 4000,    0, 0, 0, 0, 0);
		add_row(12000, 12000, 0, 0, 0,    12000, 0, 0, 0,    0, 0, 0, 0, 0);
		add_row(12000, 0, 14000, 0, 0,    0, 14000, 0, 0,    0, 0, 0, 0, 0);
		add_row(12000, 0, 0, 16000, 0,    0, 0, 16000, 0,    0, 0, 0, 0, 0);
		add_row(12345, 8192, 8192, 8192, 8192,    8192, -8192, 8192, -8192,
			0, 0, 0, 0, 0);
		add_row(24000, 8192, -8192, -8192, 8192,    -8192, 8192, 8192, -8192,
			0, 0, 0, 0, 0);
		add_row(5000,  11585, 11585, 0, 0,    0, 0, 11585, -11585,    0, 0, 0, 0, 0);
		add_row(30000, -11585, 0, 11585, 0,    0, 11585, 0, -11585,    0, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			it = directed_rows[i].item;
			expected = directed_rows[i].known ? directed_rows[i].result : predict_slerp(it);
			send_item(it, expected, idle_len());
		end

		// Every third block of a hundred transactions is sent back to back.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			it = random_item();
			gap = ((n / 100) % 3 == 1) ? 0 : idle_len();
			send_item(it, predict_slerp(it), gap);
		end
		in_if.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
sv/qslerp_pkg.sv
sv/qslerp_stream_if.sv
sv/quaternion_slerp_approx_top.sv
bench/quaternion_slerp_approx_top_test.sv
